FILE: sv/l3wh_pkg.sv
// types, constants and lane functions shared by the word hash block
// no dependencies; used by every module of lookup3_word_hash
`default_nettype none

package l3wh_pkg;

    // input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_WORD  = 1'b1;

    // register indexes on the configuration port
    localparam logic REG_SEED = 1'b0;
    localparam logic REG_LEN  = 1'b1;

    // lane that takes a key word
    localparam logic [1:0] LANE_A = 2'd0;
    localparam logic [1:0] LANE_B = 2'd1;
    localparam logic [1:0] LANE_C = 2'd2;

    localparam logic [31:0] HASH_GOLDEN = 32'hdeadbeef;

    // last step index of each mix (two rounds a step, one in the last final step)
    localparam logic [1:0] MIX_LAST_STEP   = 2'd2;
    localparam logic [1:0] FINAL_LAST_STEP = 2'd3;

    // command from the front end to the hash engine
    typedef struct packed {
        logic        is_start;  // start of message, data is the initial lane value
        logic [31:0] data;      // initial value or key word
        logic        zero;      // start of an empty message
        logic [1:0]  pos;       // lane of a key word
        logic        last;      // last key word of the message
    } t_cmd;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_lanes;

    // engine status seen at the top level
    typedef struct packed {
        logic busy;
        logic final_mode;
    } t_eng_stat;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // one round of the mix
    function automatic t_lanes mix_row(input t_lanes x, input logic [2:0] row);
        t_lanes r;
        r = x;
        case (row)
            3'd0: begin
                r.a = (x.a - x.c) ^ rotl(x.c, 4);
                r.c = x.c + x.b;
            end
            3'd1: begin
                r.b = (x.b - x.a) ^ rotl(x.a, 6);
                r.a = x.a + x.c;
            end
            3'd2: begin
                r.c = (x.c - x.b) ^ rotl(x.b, 8);
                r.b = x.b + x.a;
            end
            3'd3: begin
                r.a = (x.a - x.c) ^ rotl(x.c, 16);
                r.c = x.c + x.b;
            end
            3'd4: begin
                r.b = (x.b - x.a) ^ rotl(x.a, 19);
                r.a = x.a + x.c;
            end
            3'd5: begin
                r.c = (x.c - x.b) ^ rotl(x.b, 4);
                r.b = x.b + x.a;
            end
            default: r = x;
        endcase
        return r;
    endfunction

    // one round of the final mix
    function automatic t_lanes final_row(input t_lanes x, input logic [2:0] row);
        t_lanes r;
        r = x;
        case (row)
            3'd0: r.c = (x.c ^ x.b) - rotl(x.b, 14);
            3'd1: r.a = (x.a ^ x.c) - rotl(x.c, 11);
            3'd2: r.b = (x.b ^ x.a) - rotl(x.a, 25);
            3'd3: r.c = (x.c ^ x.b) - rotl(x.b, 16);
            3'd4: r.a = (x.a ^ x.c) - rotl(x.c, 4);
            3'd5: r.b = (x.b ^ x.a) - rotl(x.a, 14);
            3'd6: r.c = (x.c ^ x.b) - rotl(x.b, 24);
            default: r = x;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/l3wh_front.sv
// front end: classifies accepted items and tracks the open message
// depends on l3wh_pkg; feeds l3wh_cmd_fifo
`default_nettype none

module l3wh_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic                 i_operation,
    input  wire logic [31:0]          i_key_word,
    input  wire logic [29:0]          i_word_count,
    input  wire logic [31:0]          i_seed,
    input  wire logic                 i_len_in_seed,
    output      logic                 o_cmd_wr,
    output      l3wh_pkg::t_cmd       o_cmd
);

    logic        r_open;
    logic [29:0] r_left;
    logic [1:0]  r_pos;
    logic        n_open;
    logic [29:0] n_left;
    logic [1:0]  n_pos;
    logic [31:0] w_init;
    logic        w_last;

    // initial lane value of a new message
    always_comb begin
        w_init = l3wh_pkg::HASH_GOLDEN + i_seed;
        if (i_len_in_seed) begin
            w_init = w_init + {i_word_count, 2'b00};
        end
    end

    assign w_last = (r_left == 30'd1);

    // command build and message tracking
    always_comb begin
        n_open        = r_open;
        n_left        = r_left;
        n_pos         = r_pos;
        o_cmd_wr      = 1'b0;
        o_cmd.is_start = 1'b0;
        o_cmd.data    = i_key_word;
        o_cmd.zero    = 1'b0;
        o_cmd.pos     = r_pos;
        o_cmd.last    = w_last;
        if (i_operation == l3wh_pkg::OP_START) begin
            o_cmd.is_start = 1'b1;
            o_cmd.data     = w_init;
            o_cmd.zero     = (i_word_count == 30'd0);
            o_cmd.pos      = l3wh_pkg::LANE_A;
            o_cmd.last     = 1'b0;
            if (i_accept) begin
                o_cmd_wr = 1'b1;
                n_open   = (i_word_count != 30'd0);
                n_left   = i_word_count;
                n_pos    = l3wh_pkg::LANE_A;
            end
        end else if (i_accept && r_open) begin
            // stray words outside a message are dropped here
            o_cmd_wr = 1'b1;
            n_left   = r_left - 30'd1;
            if (w_last) begin
                n_open = 1'b0;
                n_pos  = l3wh_pkg::LANE_A;
            end else if (r_pos == l3wh_pkg::LANE_C) begin
                n_pos = l3wh_pkg::LANE_A;
            end else begin
                n_pos = r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
            r_pos  <= l3wh_pkg::LANE_A;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
            r_pos  <= n_pos;
        end
    end

endmodule

`default_nettype wire

FILE: sv/l3wh_cmd_fifo.sv
// short command queue between the front end and the hash engine
// depends on l3wh_pkg for the command type
`default_nettype none

module l3wh_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire l3wh_pkg::t_cmd i_wr_cmd,
    input  wire logic           i_rd,
    output      logic           o_full,
    output      logic           o_valid,
    output      l3wh_pkg::t_cmd o_rd_cmd
);

    localparam int AW = $clog2(DEPTH);

    l3wh_pkg::t_cmd r_mem [DEPTH];
    logic [AW:0]    r_wr_ptr;
    logic [AW:0]    r_rd_ptr;

    // flags from the pointer pair
    assign o_full   = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                      (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign o_valid  = (r_wr_ptr != r_rd_ptr);
    assign o_rd_cmd = r_mem[r_rd_ptr[AW-1:0]];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_wr_cmd;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_wr && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd && o_valid) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/l3wh_back.sv
// hash engine: lanes, key word group buffer, mix and final mix unit, result register
// depends on l3wh_pkg; takes commands from l3wh_cmd_fifo
`default_nettype none

module l3wh_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cmd_valid,
    input  wire l3wh_pkg::t_cmd      i_cmd,
    output      logic                o_cmd_rd,
    input  wire logic                i_pop,
    output      logic                o_empty,
    output      logic [31:0]         o_hash,
    output      l3wh_pkg::t_eng_stat o_stat
);

    l3wh_pkg::t_lanes r_lanes, n_lanes;
    logic [31:0]      r_k0, n_k0;
    logic [31:0]      r_k1, n_k1;
    logic             r_busy, n_busy;
    logic             r_final, n_final;
    logic [1:0]       r_step, n_step;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_hash, n_out_hash;

    logic             w_out_free;
    logic             w_close;
    logic [2:0]       w_row;
    l3wh_pkg::t_lanes w_mix2;
    l3wh_pkg::t_lanes w_fin1;
    l3wh_pkg::t_lanes w_fin2;

    assign w_out_free = !r_out_valid || i_pop;
    assign w_close    = !i_cmd.is_start &&
                        (i_cmd.last || (i_cmd.pos == l3wh_pkg::LANE_C));

    // two rounds per engine step, one in the last step of the final mix
    assign w_row  = {r_step, 1'b0};
    assign w_mix2 = l3wh_pkg::mix_row(l3wh_pkg::mix_row(r_lanes, w_row), w_row + 3'd1);
    assign w_fin1 = l3wh_pkg::final_row(r_lanes, w_row);
    assign w_fin2 = l3wh_pkg::final_row(w_fin1, w_row + 3'd1);

    // command issue
    always_comb begin
        o_cmd_rd = 1'b0;
        if (i_cmd_valid) begin
            if (i_cmd.is_start) begin
                o_cmd_rd = !r_busy && (!i_cmd.zero || w_out_free);
            end else begin
                o_cmd_rd = !w_close || !r_busy;
            end
        end
    end

    // engine and result register
    always_comb begin
        n_lanes     = r_lanes;
        n_k0        = r_k0;
        n_k1        = r_k1;
        n_busy      = r_busy;
        n_final     = r_final;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_pop;
        n_out_hash  = r_out_hash;

        // mix or final mix in progress
        if (r_busy) begin
            if (!r_final) begin
                n_lanes = w_mix2;
                n_step  = r_step + 2'd1;
                if (r_step == l3wh_pkg::MIX_LAST_STEP) begin
                    n_busy = 1'b0;
                end
            end else if (r_step != l3wh_pkg::FINAL_LAST_STEP) begin
                n_lanes = w_fin2;
                n_step  = r_step + 2'd1;
            end else if (w_out_free) begin
                n_lanes     = w_fin1;
                n_out_valid = 1'b1;
                n_out_hash  = w_fin1.c;
                n_busy      = 1'b0;
            end
        end

        // command from the queue
        if (o_cmd_rd) begin
            if (i_cmd.is_start) begin
                n_lanes.a = i_cmd.data;
                n_lanes.b = i_cmd.data;
                n_lanes.c = i_cmd.data;
                n_k0      = '0;
                n_k1      = '0;
                if (i_cmd.zero) begin
                    n_out_valid = 1'b1;
                    n_out_hash  = i_cmd.data;
                end
            end else if (w_close) begin
                // group closes: fold the buffered words into the lanes
                n_lanes.a = r_lanes.a +
                            ((i_cmd.pos == l3wh_pkg::LANE_A) ? i_cmd.data : r_k0);
                n_lanes.b = r_lanes.b +
                            ((i_cmd.pos == l3wh_pkg::LANE_B) ? i_cmd.data : r_k1);
                n_lanes.c = r_lanes.c +
                            ((i_cmd.pos == l3wh_pkg::LANE_C) ? i_cmd.data : 32'd0);
                n_k0      = '0;
                n_k1      = '0;
                n_busy    = 1'b1;
                n_final   = i_cmd.last;
                n_step    = '0;
            end else if (i_cmd.pos == l3wh_pkg::LANE_A) begin
                n_k0 = i_cmd.data;
            end else begin
                n_k1 = i_cmd.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lanes    <= n_lanes;
        r_k0       <= n_k0;
        r_k1       <= n_k1;
        r_out_hash <= n_out_hash;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_final     <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_final     <= n_final;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_empty           = !r_out_valid;
    assign o_hash            = r_out_hash;
    assign o_stat.busy       = r_busy;
    assign o_stat.final_mode = r_final;

endmodule

`default_nettype wire

FILE: sv/lookup3_word_hash.sv
// Word hash in the lookup3 style: a start item carries the word count, then the key words
// follow one per item and the final lane c comes out as one result. Key words are taken one per
// cycle while the queue is not full; the third word of each group waits while the mix unit, which
// runs two rounds a cycle, is busy. The final mix follows the last word, and a start waits until
// the mix unit is free. A short command queue of CMD_DEPTH entries lets the input side run ahead
// of the mix unit, and one result register lets the next item be taken while a hash waits to be
// popped. seed and length_in_seed are read at each start item and are written through the
// register port at byte addresses 0 and 4.
`default_nettype none

module lookup3_word_hash #(
    parameter int CMD_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item input
    input  wire logic        push,
    output      logic        full,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_key_word,
    input  wire logic [29:0] i_word_count,
    // result output
    output      logic        empty,
    input  wire logic        pop,
    output      logic [31:0] o_hash,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    logic                w_reg_sel;
    logic [31:0]         r_seed_val;
    logic                r_len_in_seed;
    logic                w_accept;
    logic                w_cmd_wr;
    l3wh_pkg::t_cmd      w_wr_cmd;
    logic                w_cmd_valid;
    logic                w_cmd_rd;
    l3wh_pkg::t_cmd      w_rd_cmd;
    l3wh_pkg::t_eng_stat w_stat;

    // register port
    assign pready    = 1'b1;
    assign w_reg_sel = paddr[2];
    assign prdata    = (w_reg_sel == l3wh_pkg::REG_LEN) ? {31'd0, r_len_in_seed} : r_seed_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_val    <= '0;
            r_len_in_seed <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            if (w_reg_sel == l3wh_pkg::REG_SEED) begin
                r_seed_val <= pwdata;
            end else begin
                r_len_in_seed <= pwdata[0];
            end
        end
    end

    assign w_accept = push && !full;

    // front end
    l3wh_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_operation   (i_operation),
        .i_key_word    (i_key_word),
        .i_word_count  (i_word_count),
        .i_seed        (r_seed_val),
        .i_len_in_seed (r_len_in_seed),
        .o_cmd_wr      (w_cmd_wr),
        .o_cmd         (w_wr_cmd)
    );

    // command queue
    l3wh_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_cmd_wr),
        .i_wr_cmd (w_wr_cmd),
        .i_rd     (w_cmd_rd),
        .o_full   (full),
        .o_valid  (w_cmd_valid),
        .o_rd_cmd (w_rd_cmd)
    );

    // hash engine
    l3wh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_rd_cmd),
        .o_cmd_rd    (w_cmd_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_hash      (o_hash),
        .o_stat      (w_stat)
    );

    // queue is only read when it holds a command
    a_rd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_rd |-> w_cmd_valid)
        else $error("command read from empty queue");

    // a start is only taken once the mix unit is free
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_rd && w_rd_cmd.is_start) |-> !w_stat.busy)
        else $error("start taken while mix unit busy");

    // a final mix always ends with a result waiting
    a_final_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.busy && w_stat.final_mode) ##1 !w_stat.busy |-> !empty)
        else $error("final mix ended without a result");

endmodule

`default_nettype wire

FILE: bench/l3wh_hash_checker.sv
// scoreboard for the word hash block: watches the item, result and register channels
// keeps its own copy of lanes and registers; depends on l3wh_pkg
`timescale 1ns / 100ps

module l3wh_hash_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_push,
    input  logic        i_full,
    input  logic        i_operation,
    input  logic [31:0] i_key_word,
    input  logic [29:0] i_word_count,
    // result channel
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [31:0] i_hash,
    // register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    // status for the bench
    output int          o_fail_count,
    output int          o_pending,
    output int          o_hash_count
);

    // register copies
    logic [31:0] seed_r;
    logic        len_in_seed_r;

    // lane state of the open message
    logic [31:0] lane_a;
    logic [31:0] lane_b;
    logic [31:0] lane_c;
    logic [29:0] words_left;
    logic [1:0]  next_lane;
    logic        msg_open;

    // hashes still to come, oldest first
    logic [31:0] hash_fifo[$];

    int fail_count = 0;
    int hash_count = 0;

    assign o_fail_count = fail_count;
    assign o_hash_count = hash_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] hash check: %s", $time, what);
        fail_count++;
    endtask

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // mix after each full group of three words
    task automatic stir_lanes();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = lane_a;
        b = lane_b;
        c = lane_c;
        a = a - c; a = a ^ rot_left(c, 4);  c = c + b;
        b = b - a; b = b ^ rot_left(a, 6);  a = a + c;
        c = c - b; c = c ^ rot_left(b, 8);  b = b + a;
        a = a - c; a = a ^ rot_left(c, 16); c = c + b;
        b = b - a; b = b ^ rot_left(a, 19); a = a + c;
        c = c - b; c = c ^ rot_left(b, 4);  b = b + a;
        lane_a = a;
        lane_b = b;
        lane_c = c;
    endtask

    // final mix on the last word
    task automatic finish_lanes();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        a = lane_a;
        b = lane_b;
        c = lane_c;
        c = c ^ b; c = c - rot_left(b, 14);
        a = a ^ c; a = a - rot_left(c, 11);
        b = b ^ a; b = b - rot_left(a, 25);
        c = c ^ b; c = c - rot_left(b, 16);
        a = a ^ c; a = a - rot_left(c, 4);
        b = b ^ a; b = b - rot_left(a, 14);
        c = c ^ b; c = c - rot_left(b, 24);
        lane_a = a;
        lane_b = b;
        lane_c = c;
    endtask

    // advance the lane state by one accepted item
    task automatic absorb_item(input logic op, input logic [31:0] word,
                               input logic [29:0] count);
        logic [31:0] start_value;
        if (op == l3wh_pkg::OP_START) begin
            start_value = l3wh_pkg::HASH_GOLDEN + seed_r;
            if (len_in_seed_r)
                start_value = start_value + {count, 2'b00};
            lane_a    = start_value;
            lane_b    = start_value;
            lane_c    = start_value;
            next_lane = l3wh_pkg::LANE_A;
            if (count == 30'd0) begin
                // empty key hashes to the start value
                words_left = 30'd0;
                msg_open   = 1'b0;
                hash_fifo.push_back(start_value);
            end else begin
                words_left = count;
                msg_open   = 1'b1;
            end
        end else if (msg_open) begin
            case (next_lane)
                l3wh_pkg::LANE_A: lane_a = lane_a + word;
                l3wh_pkg::LANE_B: lane_b = lane_b + word;
                default:          lane_c = lane_c + word;
            endcase
            words_left = words_left - 30'd1;
            if (words_left == 30'd0) begin
                finish_lanes();
                msg_open  = 1'b0;
                next_lane = l3wh_pkg::LANE_A;
                hash_fifo.push_back(lane_c);
            end else if (next_lane == l3wh_pkg::LANE_C) begin
                stir_lanes();
                next_lane = l3wh_pkg::LANE_A;
            end else begin
                next_lane = next_lane + 2'd1;
            end
        end
    endtask

    // channel monitor
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            seed_r        = 32'd0;
            len_in_seed_r = 1'b1;
            lane_a        = 32'd0;
            lane_b        = 32'd0;
            lane_c        = 32'd0;
            words_left    = 30'd0;
            next_lane     = l3wh_pkg::LANE_A;
            msg_open      = 1'b0;
            hash_fifo.delete();
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[1:0] == 2'b00) begin
                case (i_paddr[2])
                    l3wh_pkg::REG_SEED: seed_r = i_pwdata;
                    l3wh_pkg::REG_LEN:  len_in_seed_r = i_pwdata[0];
                    default: ;
                endcase
            end
            // results against the oldest expectation
            if (i_pop && !i_empty) begin
                if (hash_fifo.size() == 0) begin
                    report_mismatch($sformatf("hash %h popped with nothing expected", i_hash));
                end else begin
                    want = hash_fifo.pop_front();
                    hash_count++;
                    if (i_hash !== want)
                        report_mismatch($sformatf("hash got %h expected %h", i_hash, want));
                end
            end
            // accepted item
            if (i_push && !i_full)
                absorb_item(i_operation, i_key_word, i_word_count);
        end
        o_pending <= hash_fifo.size();
    end

endmodule

FILE: bench/tb.sv
// bench top for lookup3_word_hash: drives items, pops hashes and writes the registers
// depends on l3wh_pkg, the block and l3wh_hash_checker, which predicts and compares
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 175;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_operation = l3wh_pkg::OP_START;
    logic [31:0] i_key_word = 32'd0;
    logic [29:0] i_word_count = 30'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_hash;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int hash_count;
    int items_sent = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    lookup3_word_hash dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_operation  (i_operation),
        .i_key_word   (i_key_word),
        .i_word_count (i_word_count),
        .empty        (empty),
        .pop          (pop),
        .o_hash       (o_hash),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    l3wh_hash_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_operation  (i_operation),
        .i_key_word   (i_key_word),
        .i_word_count (i_word_count),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_hash       (o_hash),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_hash_count (hash_count)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side, stalls at the phase rate
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // offer one item after a random gap, return once it is taken
    task automatic push_item(input logic op, input logic [31:0] word, input logic [29:0] count);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_operation  <= op;
        i_key_word   <= word;
        i_word_count <= count;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        items_sent++;
    endtask

    // hold off the sender until every expected hash has been popped
    task automatic wait_all_hashes();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // back-to-back writes of both registers while the block is quiet
    task automatic program_registers(input logic [31:0] seed_value, input logic len_value);
        logic [31:0] values[2];
        logic        index[2];
        wait_all_hashes();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        values[0] = seed_value;
        values[1] = {31'd0, len_value};
        index[0]  = l3wh_pkg::REG_SEED;
        index[1]  = l3wh_pkg::REG_LEN;
        for (int r = 0; r < 2; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {index[r], 2'b00};
            pwdata  <= values[r];
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready)
                @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly whole messages, with cut-short messages and loose words mixed in
    task automatic run_random(input int n_items);
        int sent;
        int kind;
        int count;
        int w;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
                count = ($urandom_range(19) == 0) ? $urandom_range(90, 13) : $urandom_range(12, 0);
                push_item(l3wh_pkg::OP_START, $urandom, 30'(count));
                for (w = 0; w < count; w++)
                    push_item(l3wh_pkg::OP_WORD, $urandom, 30'($urandom));
                sent += count + 1;
            end else if (kind < 88) begin
                // huge count, abandoned by whatever start comes next
                count = $urandom_range(5, 0);
                push_item(l3wh_pkg::OP_START, $urandom, 30'($urandom));
                for (w = 0; w < count; w++)
                    push_item(l3wh_pkg::OP_WORD, $urandom, 30'($urandom));
                sent += count + 1;
            end else begin
                // loose words: dropped unless a cut-short message is still open
                count = $urandom_range(3, 1);
                for (w = 0; w < count; w++)
                    push_item(l3wh_pkg::OP_WORD, $urandom, 30'($urandom));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items under reset register values
        push_item(l3wh_pkg::OP_WORD, 32'hffffffff, 30'h3fffffff);   // stray word before any start
        push_item(l3wh_pkg::OP_START, 32'hffffffff, 30'd0);         // empty key
        push_item(l3wh_pkg::OP_START, 32'd0, 30'd1);
        push_item(l3wh_pkg::OP_WORD, 32'hffffffff, 30'd0);
        push_item(l3wh_pkg::OP_START, 32'd0, 30'd3);                // last word lands in lane c
        push_item(l3wh_pkg::OP_WORD, 32'd0, 30'd0);
        push_item(l3wh_pkg::OP_WORD, 32'hffffffff, 30'd0);
        push_item(l3wh_pkg::OP_WORD, 32'h80000001, 30'd0);
        push_item(l3wh_pkg::OP_START, 32'd0, 30'd4);                // one mix, then final
        push_item(l3wh_pkg::OP_WORD, 32'd1, 30'd0);
        push_item(l3wh_pkg::OP_WORD, 32'd2, 30'd0);
        push_item(l3wh_pkg::OP_WORD, 32'd3, 30'd0);
        push_item(l3wh_pkg::OP_WORD, 32'd4, 30'd0);
        push_item(l3wh_pkg::OP_START, 32'd0, 30'h3fffffff);         // largest count, abandoned
        push_item(l3wh_pkg::OP_WORD, 32'ha5a5a5a5, 30'd0);
        push_item(l3wh_pkg::OP_WORD, 32'h5a5a5a5a, 30'd0);
        push_item(l3wh_pkg::OP_START, 32'd0, 30'd2);
        push_item(l3wh_pkg::OP_WORD, 32'hffffffff, 30'd0);
        push_item(l3wh_pkg::OP_WORD, 32'd0, 30'd0);
        push_item(l3wh_pkg::OP_WORD, 32'h12345678, 30'd0);          // stray word after a hash
        // seed change in the middle of a message applies to the next one only
        push_item(l3wh_pkg::OP_START, 32'd0, 30'd3);
        push_item(l3wh_pkg::OP_WORD, 32'h00000001, 30'd0);
        program_registers(32'hffffffff, 1'b1);
        push_item(l3wh_pkg::OP_WORD, 32'h00000002, 30'd0);
        push_item(l3wh_pkg::OP_WORD, 32'h00000003, 30'd0);
        push_item(l3wh_pkg::OP_START, 32'd0, 30'd0);

        // random phases, one register setting and idle profile each
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: program_registers(32'd0, 1'b0);
                1: program_registers($urandom, 1'b1);
                2: program_registers(32'hffffffff, 1'b0);
                default: program_registers($urandom, 1'b1);
            endcase
            send_idle_pct  = (p == 1 || p == 3) ? ((p == 1) ? 58 : 32) : 0;
            recv_stall_pct = (p == 2 || p == 3) ? ((p == 2) ? 58 : 32) : 0;
            if (p == 1) begin
                run_random(PHASE_ITEMS / 2);
                wait_all_hashes();
                run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                run_random(PHASE_ITEMS);
            end
        end

        wait_all_hashes();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run: %0d items over four idle profiles and six register settings", items_sent);
        $display("run: %0d hashes compared, %0d mismatches", hash_count, fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
sv/l3wh_pkg.sv
sv/l3wh_front.sv
sv/l3wh_cmd_fifo.sv
sv/l3wh_back.sv
sv/lookup3_word_hash.sv
bench/l3wh_hash_checker.sv
bench/tb.sv
